// File: rtl/core/tcs_pkg.sv
package tcs_pkg;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_PIVOT = 2'd1;
    localparam logic [1:0] ST_ROWS  = 2'd2;

    typedef struct packed {
        logic [30:0]        diag_value;
        logic signed [31:0] rhs_value;
        logic               is_last;
    } tcs_in_t;

    typedef struct packed {
        logic signed [31:0] solution_value;
        logic [5:0]         row_index;
        logic               end_of_run;
        logic [1:0]         status;
    } tcs_out_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/core/tridiagonal_cholesky_solver_unit.sv
// Streaming solver for a symmetric tridiagonal system with one constant off-diagonal
// (cfg_data, signed Q16.16). Each input transaction brings one diagonal and one right-hand-side
// entry; pivots, lower factors and forward values are kept in three single-port-read RAMs.
// Each row runs two restoring divisions and one square root, a bit per cycle; the divisions share
// one divider and the root has its own datapath. The first row skips the lower-factor division.
// On the row marked last, back substitution emits one result per division in descending row
// order, taking up the next row only once the current result has been handed to the output.
// With an error recorded, a last row yields a single result carrying the status code.
// Results saturate to the signed 32-bit range. No clearing pass is needed after reset.
module tridiagonal_cholesky_solver_unit
    import tcs_pkg::*;
#(
    parameter int MAX_LEN   = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  tcs_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output tcs_out_t    m_data
);

    localparam int AW   = $clog2(MAX_LEN);
    localparam int CW   = $clog2(MAX_LEN + 1);
    localparam int NW   = 33 + FRAC_BITS;
    localparam int VW   = 31 + FRAC_BITS;
    localparam int SQ   = (VW + 1) / 2;
    localparam int SW   = 2 * SQ;
    localparam int CNTW = $clog2(NW);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_DISP   = 5'd1;
    localparam logic [4:0] S_RDWAIT = 5'd2;
    localparam logic [4:0] S_LDIV   = 5'd3;
    localparam logic [4:0] S_LSAT   = 5'd4;
    localparam logic [4:0] S_LMUL   = 5'd5;
    localparam logic [4:0] S_TCALC  = 5'd6;
    localparam logic [4:0] S_YCALC  = 5'd7;
    localparam logic [4:0] S_TCHK   = 5'd8;
    localparam logic [4:0] S_SQRT   = 5'd9;
    localparam logic [4:0] S_PSTORE = 5'd10;
    localparam logic [4:0] S_YDIV   = 5'd11;
    localparam logic [4:0] S_YSTORE = 5'd12;
    localparam logic [4:0] S_FINISH = 5'd13;
    localparam logic [4:0] S_ERROUT = 5'd14;
    localparam logic [4:0] S_BREAD  = 5'd15;
    localparam logic [4:0] S_BWAIT  = 5'd16;
    localparam logic [4:0] S_BNUM   = 5'd17;
    localparam logic [4:0] S_BDIV   = 5'd18;
    localparam logic [4:0] S_BOUT   = 5'd19;

    logic [4:0]         state_reg, state_next;
    logic [31:0]        off_reg;
    tcs_in_t            in_reg;
    logic [CW-1:0]      row_cnt_reg;
    logic [1:0]         err_reg;
    logic signed [31:0] l_reg, fp_reg, piv_reg, fb_reg, x_reg;
    logic signed [63:0] t_reg, y_reg, prod_reg;
    logic [AW-1:0]      r_reg;
    logic               first_reg;
    logic [CNTW-1:0]    cnt_reg;
    logic               m_valid_reg;
    tcs_out_t           m_data_reg;

    logic               div_neg_reg;
    logic [NW-1:0]      div_quo_reg;
    logic [32:0]        div_rem_reg;
    logic [31:0]        div_den_reg;
    logic [SW-1:0]      sq_v_reg, sq_r_reg, sq_bit_reg;

    logic [AW-1:0]      j_idx, jm1_idx, rd_addr;
    logic [31:0]        piv_rd, low_rd, fwd_rd;
    logic               div_ld;
    logic signed [31:0] div_num;
    logic [31:0]        div_den;
    logic [32:0]        div_nx, div_mag, div_rsh;
    logic               div_ge;
    logic signed [31:0] div_res;
    logic [SW:0]        sq_sum;
    logic               sq_ge;
    logic               out_free;
    logic               out_load;
    logic               cnt_done;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign out_free  = !m_valid_reg || m_ready;
    assign out_load  = out_free && (state_reg == S_ERROUT || state_reg == S_BOUT);
    assign cnt_done  = (cnt_reg == '0);

    assign j_idx   = row_cnt_reg[AW-1:0];
    assign jm1_idx = AW'(j_idx - 1'b1);
    assign rd_addr = (state_reg == S_BREAD) ? r_reg : jm1_idx;

    tcs_ram #(.WIDTH(32), .DEPTH(MAX_LEN)) u_pivot (
        .aclk(aclk), .wr_en(state_reg == S_PSTORE), .wr_addr(j_idx),
        .wr_data(sq_r_reg[31:0]), .rd_addr(rd_addr), .rd_data(piv_rd)
    );

    tcs_ram #(.WIDTH(32), .DEPTH(MAX_LEN)) u_lower (
        .aclk(aclk), .wr_en(state_reg == S_LSAT), .wr_addr(jm1_idx),
        .wr_data(div_res), .rd_addr(rd_addr), .rd_data(low_rd)
    );

    tcs_ram #(.WIDTH(32), .DEPTH(MAX_LEN)) u_fwd (
        .aclk(aclk), .wr_en(state_reg == S_YSTORE), .wr_addr(j_idx),
        .wr_data(div_res), .rd_addr(rd_addr), .rd_data(fwd_rd)
    );

    // divider operand select: lower factor, forward value, back substitution
    always_comb begin
        div_ld  = 1'b0;
        div_num = '0;
        div_den = '0;
        unique case (state_reg)
            S_RDWAIT: begin
                div_ld  = 1'b1;
                div_num = off_reg;
                div_den = piv_rd;
            end
            S_PSTORE: begin
                div_ld  = 1'b1;
                div_num = sat32($signed({{32{in_reg.rhs_value[31]}}, in_reg.rhs_value}) - y_reg);
                div_den = sq_r_reg[31:0];
            end
            S_BNUM: begin
                div_ld  = 1'b1;
                div_num = sat32($signed({{32{fb_reg[31]}}, fb_reg})
                                - (first_reg ? 64'sd0 : (prod_reg >>> FRAC_BITS)));
                div_den = piv_reg;
            end
            default: begin
                div_ld = 1'b0;
            end
        endcase
    end

    assign div_nx  = {div_num[31], div_num};
    assign div_mag = div_num[31] ? (~div_nx + 33'd1) : div_nx;
    assign div_rsh = {div_rem_reg[31:0], div_quo_reg[NW-1]};
    assign div_ge  = (div_rsh >= {1'b0, div_den_reg});

    // truncated quotient magnitude, signed and saturated
    always_comb begin
        if (!div_neg_reg) begin
            div_res = (|div_quo_reg[NW-1:31]) ? 32'sh7fffffff : div_quo_reg[31:0];
        end else if ((|div_quo_reg[NW-1:32]) || (div_quo_reg[31] && (|div_quo_reg[30:0]))) begin
            div_res = 32'sh80000000;
        end else begin
            div_res = -div_quo_reg[31:0];
        end
    end

    assign sq_sum = {1'b0, sq_r_reg} + {1'b0, sq_bit_reg};
    assign sq_ge  = ({1'b0, sq_v_reg} >= sq_sum);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (s_valid) state_next = S_DISP;
            S_DISP: begin
                if (row_cnt_reg >= CW'(MAX_LEN) || err_reg != ST_OK) begin
                    state_next = S_FINISH;
                end else if (row_cnt_reg == '0) begin
                    state_next = S_TCHK;
                end else begin
                    state_next = S_RDWAIT;
                end
            end
            S_RDWAIT: state_next = S_LDIV;
            S_LDIV:   if (cnt_done) state_next = S_LSAT;
            S_LSAT:   state_next = S_LMUL;
            S_LMUL:   state_next = S_TCALC;
            S_TCALC:  state_next = S_YCALC;
            S_YCALC:  state_next = S_TCHK;
            S_TCHK:   state_next = (t_reg <= 64'sd0) ? S_FINISH : S_SQRT;
            S_SQRT:   if (cnt_done) state_next = S_PSTORE;
            S_PSTORE: state_next = S_YDIV;
            S_YDIV:   if (cnt_done) state_next = S_YSTORE;
            S_YSTORE: state_next = S_FINISH;
            S_FINISH: begin
                if (!in_reg.is_last) begin
                    state_next = S_IDLE;
                end else if (err_reg != ST_OK || row_cnt_reg == '0) begin
                    state_next = S_ERROUT;
                end else begin
                    state_next = S_BREAD;
                end
            end
            S_ERROUT: if (out_free) state_next = S_IDLE;
            S_BREAD:  state_next = S_BWAIT;
            S_BWAIT:  state_next = S_BNUM;
            S_BNUM:   state_next = S_BDIV;
            S_BDIV:   if (cnt_done) state_next = S_BOUT;
            S_BOUT: begin
                if (out_free) state_next = (r_reg == '0) ? S_IDLE : S_BREAD;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            off_reg     <= '0;
            row_cnt_reg <= '0;
            err_reg     <= ST_OK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                off_reg <= cfg_data;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_DISP: begin
                    if (row_cnt_reg >= CW'(MAX_LEN)) begin
                        if (err_reg == ST_OK) err_reg <= ST_ROWS;
                    end else if (err_reg != ST_OK) begin
                        row_cnt_reg <= row_cnt_reg + 1'b1;
                    end
                end
                S_TCHK: begin
                    if (t_reg <= 64'sd0) begin
                        err_reg     <= ST_PIVOT;
                        row_cnt_reg <= row_cnt_reg + 1'b1;
                    end
                end
                S_YSTORE: row_cnt_reg <= row_cnt_reg + 1'b1;
                S_ERROUT: begin
                    if (out_free) begin
                        row_cnt_reg <= '0;
                        err_reg     <= ST_OK;
                    end
                end
                S_BOUT: begin
                    if (out_free) begin
                        if (r_reg == '0) begin
                            row_cnt_reg <= '0;
                            err_reg     <= ST_OK;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // datapath: no reset
    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && s_valid) begin
            in_reg <= s_data;
        end

        if (div_ld) begin
            div_neg_reg <= div_num[31];
            div_quo_reg <= {div_mag, {FRAC_BITS{1'b0}}};
            div_rem_reg <= '0;
            div_den_reg <= div_den;
            cnt_reg     <= CNTW'(NW - 1);
        end else if (state_reg == S_LDIV || state_reg == S_YDIV || state_reg == S_BDIV) begin
            div_rem_reg <= div_ge ? (div_rsh - {1'b0, div_den_reg}) : div_rsh;
            div_quo_reg <= {div_quo_reg[NW-2:0], div_ge};
            cnt_reg     <= cnt_reg - 1'b1;
        end else if (state_reg == S_TCHK) begin
            sq_v_reg   <= SW'({t_reg[30:0], {FRAC_BITS{1'b0}}});
            sq_r_reg   <= '0;
            sq_bit_reg <= {2'b01, {(SW-2){1'b0}}};
            cnt_reg    <= CNTW'(SQ - 1);
        end else if (state_reg == S_SQRT) begin
            if (sq_ge) begin
                sq_v_reg <= sq_v_reg - sq_sum[SW-1:0];
                sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
            end else begin
                sq_r_reg <= sq_r_reg >> 1;
            end
            sq_bit_reg <= sq_bit_reg >> 2;
            cnt_reg    <= cnt_reg - 1'b1;
        end

        unique case (state_reg)
            S_DISP: begin
                t_reg <= $signed({33'd0, in_reg.diag_value});
                y_reg <= '0;
            end
            S_RDWAIT: fp_reg <= fwd_rd;
            S_LSAT:   l_reg <= div_res;
            S_LMUL:   prod_reg <= l_reg * l_reg;
            S_TCALC: begin
                t_reg    <= $signed({33'd0, in_reg.diag_value}) - (prod_reg >>> FRAC_BITS);
                prod_reg <= l_reg * fp_reg;
            end
            S_YCALC:  y_reg <= prod_reg >>> FRAC_BITS;
            S_FINISH: begin
                r_reg     <= AW'(row_cnt_reg - 1'b1);
                first_reg <= 1'b1;
            end
            S_ERROUT: begin
                if (out_free) begin
                    m_data_reg <= '{solution_value: '0, row_index: '0,
                                    end_of_run: 1'b1, status: err_reg};
                end
            end
            S_BWAIT: begin
                prod_reg <= $signed(low_rd) * x_reg;
                piv_reg  <= piv_rd;
                fb_reg   <= fwd_rd;
            end
            S_BOUT: begin
                if (out_free) begin
                    x_reg      <= div_res;
                    m_data_reg <= '{solution_value: div_res, row_index: 6'(r_reg),
                                    end_of_run: (r_reg == '0), status: ST_OK};
                    r_reg      <= AW'(r_reg - 1'b1);
                    first_reg  <= 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    a_row_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        row_cnt_reg <= CW'(MAX_LEN))
        else $error("row count beyond store depth");

    a_err_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.status != ST_OK)
            |-> (m_data_reg.end_of_run && m_data_reg.row_index == 6'd0))
        else $error("error result not a single row-zero transaction");

    a_pivot_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_YDIV) |-> (div_den_reg != 32'd0))
        else $error("forward division by zero pivot");

    a_bout_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_BOUT && out_free) |=> m_valid_reg)
        else $error("back substitution result not loaded");

endmodule

// File: rtl/core/tcs_ram.sv
module tcs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
